// ===== design/quick_disk_track_framer_core_defines.svh =====
// Assertion macros shared by the framer RTL.
// Every assertion samples on clk_i and is switched off while rst_ni is low.
`ifndef QUICK_DISK_TRACK_FRAMER_CORE_DEFINES_SVH
`define QUICK_DISK_TRACK_FRAMER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QDTF_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QDTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/qdtf_pkg.sv =====
package qdtf_pkg;

  localparam int unsigned DEFAULT_SECTOR_BYTES = 128;

  localparam int unsigned BYTE_CNT_W = 12;
  localparam int unsigned SECTOR_CNT_W = 10;
  localparam int unsigned PREAMBLE_W = 12;
  localparam int unsigned SECTORS_W = 10;
  localparam int unsigned TRAILER_W = 10;
  localparam int unsigned LEN_W = BYTE_CNT_W + 1;

  localparam logic [7:0] SYNC_BYTE = 8'h16;
  localparam logic [7:0] ID_MARK = 8'hA5;
  localparam logic [7:0] DATA_MARK = 8'h5A;
  localparam logic [LEN_W-1:0] HEAD_SYNC_LEN = LEN_W'(17);
  localparam logic [LEN_W-1:0] DATA_SYNC_LEN = LEN_W'(10);

  localparam logic [PREAMBLE_W-1:0] PREAMBLE_RESET = PREAMBLE_W'(2500);
  localparam logic [SECTORS_W-1:0] SECTORS_RESET = SECTORS_W'(400);
  localparam logic [TRAILER_W-1:0] TRAILER_RESET = TRAILER_W'(128);

  // Register indexes on the configuration port (word address bits [3:2]).
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_PREAMBLE = 2'd0;
  localparam logic [1:0] REG_SECTORS = 2'd1;
  localparam logic [1:0] REG_TRAILER = 2'd2;

endpackage

// ===== design/quick_disk_track_framer_core.sv =====
// A request is held in the input register and then in the output register before its track
// byte is offered downstream.
// Throughput: one track byte per cycle, sustained while m_axis_tready does not stall the output.
// The input register and the output register let a request enter while a result waits.
// Reset (rst_ni low, asynchronous): pipeline empty, track restarts at the preamble,
// and the registers return to 2500 preamble bytes, 400 sectors and 128 trailer bytes.
`include "quick_disk_track_framer_core_defines.svh"

module quick_disk_track_framer_core
  import qdtf_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES = DEFAULT_SECTOR_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] payload_byte
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] track_byte
  output logic                  m_axis_tuser,   // [0] payload_taken
  output logic                  m_axis_tlast    // track_end
);

  // Track layout phases, in the order they are written.
  typedef enum logic [3:0] {
    PH_PREAMBLE,
    PH_HSYNC,
    PH_IDMARK,
    PH_NUMHI,
    PH_NUMLO,
    PH_HSUM,
    PH_DSYNC,
    PH_DMARK,
    PH_DATA,
    PH_DSUM,
    PH_TRAILER
  } phase_e;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access cycle of the port;
  // pready is tied high, so no access is ever extended.
  // ---------------------------------------------------------------------------
  logic [PREAMBLE_W-1:0] preamble_len_q;
  logic [SECTORS_W-1:0]  sectors_q;
  logic [TRAILER_W-1:0]  trailer_len_q;
  logic                  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_len_q <= PREAMBLE_RESET;
      sectors_q      <= SECTORS_RESET;
      trailer_len_q  <= TRAILER_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_PREAMBLE: preamble_len_q <= pwdata[PREAMBLE_W-1:0];
        REG_SECTORS:  sectors_q      <= pwdata[SECTORS_W-1:0];
        REG_TRAILER:  trailer_len_q  <= pwdata[TRAILER_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PREAMBLE: prdata = 32'(preamble_len_q);
      REG_SECTORS:  prdata = 32'(sectors_q);
      REG_TRAILER:  prdata = 32'(trailer_len_q);
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. It holds one request while the output register is stalled,
  // so the upstream side keeps moving as long as this slot is free.
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_payload_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_taken_q;
  logic       out_end_q;
  logic       pipe_adv;
  logic       fire;

  assign pipe_adv      = ~out_valid_q | m_axis_tready;
  assign fire          = in_valid_q & pipe_adv;
  assign s_axis_tready = ~in_valid_q | pipe_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_payload_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Framing state: current phase, position inside it, current sector and the
  // two running checksums.
  // ---------------------------------------------------------------------------
  phase_e                  phase_q, phase_d;
  logic [BYTE_CNT_W-1:0]   byte_cnt_q, byte_cnt_d;
  logic [SECTOR_CNT_W-1:0] sector_cnt_q, sector_cnt_d;
  logic [7:0]              header_sum_q, header_sum_d;
  logic [7:0]              data_sum_q, data_sum_d;

  logic pre_zero, sec_zero, trl_zero, all_zero, sector_phase;
  logic one_byte_phase;

  // Effective position after skipping phases that have become empty.
  phase_e                  eff_phase;
  logic [BYTE_CNT_W-1:0]   eff_byte;
  logic [SECTOR_CNT_W-1:0] eff_sector;

  logic [LEN_W-1:0]        phase_len;
  logic [LEN_W-1:0]        next_pos;
  logic                    phase_done;
  logic [SECTOR_CNT_W:0]   number;
  logic [7:0]              byte_d;
  logic                    taken_d;
  logic                    end_d;

  assign pre_zero     = (preamble_len_q == '0);
  assign sec_zero     = (sectors_q == '0);
  assign trl_zero     = (trailer_len_q == '0);
  assign all_zero     = pre_zero & sec_zero & trl_zero;
  assign sector_phase = (phase_q != PH_PREAMBLE) && (phase_q != PH_TRAILER);

  // Marks and checksums occupy a single byte each.
  assign one_byte_phase = (phase_q == PH_IDMARK) || (phase_q == PH_NUMHI) ||
                          (phase_q == PH_NUMLO) || (phase_q == PH_HSUM) ||
                          (phase_q == PH_DMARK) || (phase_q == PH_DSUM);

  // A phase left empty by a register write is skipped before the byte is made.
  // Any skip restarts the position and the sector count.
  always_comb begin
    priority if (all_zero) begin
      eff_phase  = PH_PREAMBLE;
      eff_byte   = '0;
      eff_sector = '0;
    end else if (sector_phase && sec_zero) begin
      eff_phase  = trl_zero ? PH_PREAMBLE : PH_TRAILER;
      eff_byte   = '0;
      eff_sector = '0;
    end else if ((phase_q == PH_PREAMBLE) && pre_zero) begin
      eff_phase  = sec_zero ? PH_TRAILER : PH_HSYNC;
      eff_byte   = '0;
      eff_sector = '0;
    end else if ((phase_q == PH_TRAILER) && trl_zero) begin
      eff_phase  = pre_zero ? PH_HSYNC : PH_PREAMBLE;
      eff_byte   = '0;
      eff_sector = '0;
    end else begin
      eff_phase  = phase_q;
      eff_byte   = byte_cnt_q;
      eff_sector = sector_cnt_q;
    end
  end

  always_comb begin
    unique case (eff_phase)
      PH_PREAMBLE: phase_len = LEN_W'(preamble_len_q);
      PH_HSYNC:    phase_len = HEAD_SYNC_LEN;
      PH_DSYNC:    phase_len = DATA_SYNC_LEN;
      PH_DATA:     phase_len = LEN_W'(SECTOR_BYTES);
      PH_TRAILER:  phase_len = LEN_W'(trailer_len_q);
      default:     phase_len = LEN_W'(1);
    endcase
  end

  assign next_pos   = LEN_W'(eff_byte) + LEN_W'(1);
  assign phase_done = (next_pos >= phase_len);
  assign number     = (SECTOR_CNT_W + 1)'(eff_sector) + (SECTOR_CNT_W + 1)'(1);

  // Byte generation and checksum tracking.
  always_comb begin
    byte_d       = SYNC_BYTE;
    taken_d      = 1'b0;
    header_sum_d = header_sum_q;
    data_sum_d   = data_sum_q;
    if (!all_zero) begin
      unique case (eff_phase)
        PH_IDMARK: byte_d = ID_MARK;
        PH_NUMHI:  byte_d = 8'(number[SECTOR_CNT_W:8]);
        PH_NUMLO: begin
          byte_d       = number[7:0];
          header_sum_d = ID_MARK + 8'(number[SECTOR_CNT_W:8]) + number[7:0];
        end
        PH_HSUM:   byte_d = header_sum_q;
        PH_DMARK: begin
          byte_d     = DATA_MARK;
          data_sum_d = DATA_MARK;
        end
        PH_DATA: begin
          byte_d     = in_payload_q;
          taken_d    = 1'b1;
          data_sum_d = data_sum_q + in_payload_q;
        end
        PH_DSUM:   byte_d = data_sum_q;
        default:   byte_d = SYNC_BYTE;
      endcase
    end
  end

  // Phase sequencing. At the end of a phase the next non-empty phase is picked directly; track_end
  // goes high whenever that step passes the trailer, and on every byte while all lengths are zero.
  always_comb begin
    phase_d      = eff_phase;
    byte_cnt_d   = eff_byte;
    sector_cnt_d = eff_sector;
    end_d        = 1'b0;
    if (all_zero) begin
      phase_d      = PH_PREAMBLE;
      byte_cnt_d   = '0;
      sector_cnt_d = '0;
      end_d        = 1'b1;
    end else if (!phase_done) begin
      byte_cnt_d = next_pos[BYTE_CNT_W-1:0];
    end else begin
      byte_cnt_d = '0;
      unique case (eff_phase)
        PH_TRAILER: begin
          end_d        = 1'b1;
          sector_cnt_d = '0;
          if (!pre_zero) begin
            phase_d = PH_PREAMBLE;
          end else if (!sec_zero) begin
            phase_d = PH_HSYNC;
          end else begin
            phase_d = PH_TRAILER;
          end
        end
        PH_PREAMBLE: begin
          sector_cnt_d = '0;
          if (!sec_zero) begin
            phase_d = PH_HSYNC;
          end else if (!trl_zero) begin
            phase_d = PH_TRAILER;
          end else begin
            phase_d = PH_PREAMBLE;
            end_d   = 1'b1;
          end
        end
        PH_DSUM: begin
          if (number >= (SECTOR_CNT_W + 1)'(sectors_q)) begin
            if (!trl_zero) begin
              phase_d = PH_TRAILER;
            end else begin
              end_d        = 1'b1;
              sector_cnt_d = '0;
              phase_d      = pre_zero ? PH_HSYNC : PH_PREAMBLE;
            end
          end else begin
            sector_cnt_d = number[SECTOR_CNT_W-1:0];
            phase_d      = PH_HSYNC;
          end
        end
        PH_HSYNC:  phase_d = PH_IDMARK;
        PH_IDMARK: phase_d = PH_NUMHI;
        PH_NUMHI:  phase_d = PH_NUMLO;
        PH_NUMLO:  phase_d = PH_HSUM;
        PH_HSUM:   phase_d = PH_DSYNC;
        PH_DSYNC:  phase_d = PH_DMARK;
        PH_DMARK:  phase_d = PH_DATA;
        PH_DATA:   phase_d = PH_DSUM;
        default:   phase_d = PH_PREAMBLE;
      endcase
    end
  end

  // Framing state and the output register move together: the byte made from
  // the waiting request is captured in the same edge that advances the phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_PREAMBLE;
      byte_cnt_q   <= '0;
      sector_cnt_q <= '0;
      header_sum_q <= '0;
      data_sum_q   <= '0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_taken_q  <= 1'b0;
      out_end_q    <= 1'b0;
    end else begin
      if (pipe_adv) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        phase_q      <= phase_d;
        byte_cnt_q   <= byte_cnt_d;
        sector_cnt_q <= sector_cnt_d;
        header_sum_q <= header_sum_d;
        data_sum_q   <= data_sum_d;
        out_byte_q   <= byte_d;
        out_taken_q  <= taken_d;
        out_end_q    <= end_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_taken_q;
  assign m_axis_tlast  = out_end_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A payload byte is never the last byte of a track.
  `QDTF_ASSERT(a_taken_not_end, out_valid_q, !(out_taken_q && out_end_q), "payload at track end")
  // Single-byte phases always sit at position zero.
  `QDTF_ASSERT(a_short_phase_pos, one_byte_phase, byte_cnt_q == '0, "count in one-byte phase")
  // A request held in the input register is not dropped while the output stalls.
  `QDTF_ASSERT_NEXT(a_input_held, in_valid_q && !pipe_adv, in_valid_q, "stalled request lost")
  // A result only appears when a request was waiting in the input register.
  `QDTF_ASSERT(a_out_from_in, $rose(out_valid_q), $past(in_valid_q), "result without request")

endmodule
